>>> src/dfol_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dfol_pkg;

    localparam int DEF_RATE_WIDTH = 48;

    localparam int POS_W      = 32;
    localparam int TIME_W     = 16;
    localparam int DIST_W     = 33;
    localparam int DIST_S_W   = 32;
    localparam int ROOT_STEPS = 32;
    // numerator widths of the divides: (2*dist) << 16, and step * magnitude
    localparam int RAW_NUM_W  = 50;
    localparam int MOVE_NUM_W = 65;

    localparam logic [TIME_W-1:0] APPROACH_RESET = 16'd32768;

    localparam logic [1:0] CFG_APPROACH_TIME = 2'd0;
    localparam logic [1:0] CFG_START_X       = 2'd1;
    localparam logic [1:0] CFG_START_Y       = 2'd2;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_DIFF,
        OP_SQUARE,
        OP_SUM,
        OP_ROOT,
        OP_DIST,
        OP_DIV_LOAD_RAW,
        OP_DIV_STEP,
        OP_RAW,
        OP_DECEL,
        OP_STILL,
        OP_DEC,
        OP_VEL,
        OP_STEP,
        OP_SNAP,
        OP_PRODX,
        OP_MOVEX,
        OP_PRODY,
        OP_MOVEY,
        OP_EMIT
    } dp_op_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DIFF,
        ST_SQUARE,
        ST_SUM,
        ST_ROOT,
        ST_DIST,
        ST_ROUTE,
        ST_DIV_RAW,
        ST_RAW,
        ST_DIV_DECEL,
        ST_DECEL,
        ST_VEL,
        ST_STEP,
        ST_PRODX,
        ST_DIVX,
        ST_MOVEX,
        ST_PRODY,
        ST_DIVY,
        ST_MOVEY,
        ST_EMIT
    } ctl_state_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic new_tgt;
        logic dist_zero;
        logic dec_lt;
        logic step_lt;
    } dp_sts_t;

endpackage

`default_nettype wire

>>> src/dfol_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module dfol_datapath
    import dfol_pkg::*;
#(
    parameter int RATE_WIDTH = DEF_RATE_WIDTH
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     wr_en,
    input  wire logic [1:0]               wr_index,
    input  wire logic [POS_W-1:0]         wr_data,
    input  wire logic [TIME_W-1:0]        tick_length,
    input  wire logic                     target_valid,
    input  wire logic signed [POS_W-1:0]  goal_x,
    input  wire logic signed [POS_W-1:0]  goal_y,
    input  wire dp_cmd_t                  cmd,
    output dp_sts_t                       sts,
    output logic signed [POS_W-1:0]       cam_x,
    output logic signed [POS_W-1:0]       cam_y,
    output logic                          moving
);

    localparam int DW = (RATE_WIDTH + TIME_W > MOVE_NUM_W) ? RATE_WIDTH + TIME_W : MOVE_NUM_W;
    localparam logic [RATE_WIDTH-1:0] RATE_MAX = '1;
    localparam logic [63:0] ROOT_BIT_INIT = 64'h4000_0000_0000_0000;

    // configuration
    logic [TIME_W-1:0] approach_reg;
    logic [POS_W-1:0]  start_x_reg, start_y_reg;

    // architectural state
    logic                  started_reg, started_next;
    logic [POS_W-1:0]      pos_x_reg, pos_x_next, pos_y_reg, pos_y_next;
    logic [POS_W-1:0]      last_x_reg, last_x_next, last_y_reg, last_y_next;
    logic [RATE_WIDTH-1:0] speed_reg, speed_next, decel_reg, decel_next;
    logic                  new_tgt_reg, new_tgt_next;
    logic                  moving_reg, moving_next;

    // working registers
    logic [TIME_W-1:0]     dt_reg, dt_next;
    logic [DIST_S_W-1:0]   ax_reg, ax_next, ay_reg, ay_next;
    logic                  neg_x_reg, neg_x_next, neg_y_reg, neg_y_next;
    logic                  sh_reg, sh_next;
    logic [63:0]           sqx_reg, sqx_next, sqy_reg, sqy_next;
    logic [63:0]           rn_reg, rn_next, res_reg, res_next, bit_reg, bit_next;
    logic [DIST_S_W-1:0]   dist_s_reg, dist_s_next;
    logic [DIST_W-1:0]     dist_reg, dist_next;
    logic [DW-1:0]         num_reg, num_next;
    logic [31:0]           rem_reg, rem_next, den_reg, den_next;
    logic [RATE_WIDTH-1:0] quo_reg, quo_next;
    logic                  ovf_reg, ovf_next;
    logic [RATE_WIDTH-1:0] dec_reg, dec_next, vel_reg, vel_next, step_reg, step_next;
    logic [POS_W-1:0]      cam_x_reg, cam_x_next, cam_y_reg, cam_y_next;
    logic                  cam_mv_reg, cam_mv_next;

    // combinational helpers
    logic [POS_W:0]               dx, dy, adx, ady;
    logic                         shift;
    logic [63:0]                  trial;
    logic                         root_ge;
    logic [32:0]                  rem_sh, rem_sub;
    logic                         div_ge;
    logic [TIME_W-1:0]            t_eff;
    logic [RATE_WIDTH-1:0]        qsat;
    logic [RATE_WIDTH-1:0]        mop;
    logic [RATE_WIDTH+TIME_W-1:0] tprod;
    logic [RATE_WIDTH-1:0]        tres;
    logic [DIST_S_W-1:0]          mag;
    logic [MOVE_NUM_W-1:0]        prod;

    assign dx  = {last_x_reg[POS_W-1], last_x_reg} - {pos_x_reg[POS_W-1], pos_x_reg};
    assign dy  = {last_y_reg[POS_W-1], last_y_reg} - {pos_y_reg[POS_W-1], pos_y_reg};
    assign adx = dx[POS_W] ? (~dx + 1'b1) : dx;
    assign ady = dy[POS_W] ? (~dy + 1'b1) : dy;
    assign shift = adx[POS_W] | adx[POS_W-1] | ady[POS_W] | ady[POS_W-1];

    assign trial   = res_reg + bit_reg;
    assign root_ge = rn_reg >= trial;

    assign rem_sh  = {rem_reg, num_reg[DW-1]};
    assign rem_sub = rem_sh - {1'b0, den_reg};
    assign div_ge  = rem_sh >= {1'b0, den_reg};

    assign t_eff = (approach_reg == '0) ? TIME_W'(1) : approach_reg;
    assign qsat  = ovf_reg ? RATE_MAX : quo_reg;

    assign mop   = (cmd.op == OP_DEC) ? decel_reg : vel_reg;
    assign tprod = mop * dt_reg;
    assign tres  = tprod[RATE_WIDTH+TIME_W-1:TIME_W];

    assign mag  = (cmd.op == OP_PRODY) ? ay_reg : ax_reg;
    assign prod = step_reg[DIST_W-1:0] * mag;

    always_comb
    begin
        started_next = started_reg;
        pos_x_next   = pos_x_reg;
        pos_y_next   = pos_y_reg;
        last_x_next  = last_x_reg;
        last_y_next  = last_y_reg;
        speed_next   = speed_reg;
        decel_next   = decel_reg;
        new_tgt_next = new_tgt_reg;
        moving_next  = moving_reg;
        dt_next      = dt_reg;
        ax_next      = ax_reg;
        ay_next      = ay_reg;
        neg_x_next   = neg_x_reg;
        neg_y_next   = neg_y_reg;
        sh_next      = sh_reg;
        sqx_next     = sqx_reg;
        sqy_next     = sqy_reg;
        rn_next      = rn_reg;
        res_next     = res_reg;
        bit_next     = bit_reg;
        dist_s_next  = dist_s_reg;
        dist_next    = dist_reg;
        num_next     = num_reg;
        rem_next     = rem_reg;
        den_next     = den_reg;
        quo_next     = quo_reg;
        ovf_next     = ovf_reg;
        dec_next     = dec_reg;
        vel_next     = vel_reg;
        step_next    = step_reg;
        cam_x_next   = cam_x_reg;
        cam_y_next   = cam_y_reg;
        cam_mv_next  = cam_mv_reg;
        case (cmd.op)
            OP_LOAD:
            begin
                dt_next = tick_length;
                if (!started_reg)
                begin
                    pos_x_next   = start_x_reg;
                    pos_y_next   = start_y_reg;
                    started_next = 1'b1;
                end
                if (target_valid && ((goal_x != last_x_reg) || (goal_y != last_y_reg)))
                begin
                    last_x_next  = goal_x;
                    last_y_next  = goal_y;
                    new_tgt_next = 1'b1;
                end
                else
                begin
                    new_tgt_next = 1'b0;
                end
            end
            OP_DIFF:
            begin
                neg_x_next = dx[POS_W];
                neg_y_next = dy[POS_W];
                sh_next    = shift;
                ax_next    = shift ? adx[POS_W:1] : adx[POS_W-1:0];
                ay_next    = shift ? ady[POS_W:1] : ady[POS_W-1:0];
            end
            OP_SQUARE:
            begin
                sqx_next = ax_reg * ax_reg;
                sqy_next = ay_reg * ay_reg;
            end
            OP_SUM:
            begin
                rn_next  = sqx_reg + sqy_reg;
                res_next = '0;
                bit_next = ROOT_BIT_INIT;
            end
            OP_ROOT:
            begin
                if (root_ge)
                begin
                    rn_next  = rn_reg - trial;
                    res_next = (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_next = res_reg >> 1;
                end
                bit_next = bit_reg >> 2;
            end
            OP_DIST:
            begin
                dist_s_next = res_reg[DIST_S_W-1:0];
                dist_next   = sh_reg ? {res_reg[DIST_S_W-1:0], 1'b0}
                                     : {1'b0, res_reg[DIST_S_W-1:0]};
            end
            OP_DIV_LOAD_RAW:
            begin
                num_next = DW'({dist_reg, 1'b0, {TIME_W{1'b0}}}) << (DW - RAW_NUM_W);
                den_next = {{(32-TIME_W){1'b0}}, t_eff};
                rem_next = '0;
                quo_next = '0;
                ovf_next = 1'b0;
            end
            OP_DIV_STEP:
            begin
                num_next = num_reg << 1;
                rem_next = div_ge ? rem_sub[31:0] : rem_sh[31:0];
                quo_next = {quo_reg[RATE_WIDTH-2:0], div_ge};
                ovf_next = ovf_reg | quo_reg[RATE_WIDTH-1];
            end
            OP_RAW:
            begin
                speed_next = qsat;
                num_next   = DW'({qsat, {TIME_W{1'b0}}}) << (DW - RATE_WIDTH - TIME_W);
                rem_next   = '0;
                quo_next   = '0;
                ovf_next   = 1'b0;
            end
            OP_DECEL:
            begin
                decel_next   = qsat;
                new_tgt_next = 1'b0;
            end
            OP_STILL:
            begin
                moving_next = 1'b0;
            end
            OP_DEC:
            begin
                dec_next = tres;
            end
            OP_VEL:
            begin
                vel_next = speed_reg - dec_reg;
            end
            OP_STEP:
            begin
                step_next = tres;
            end
            OP_SNAP:
            begin
                pos_x_next  = last_x_reg;
                pos_y_next  = last_y_reg;
                speed_next  = '0;
                decel_next  = '0;
                moving_next = 1'b0;
            end
            OP_PRODX, OP_PRODY:
            begin
                num_next = DW'(prod) << (DW - MOVE_NUM_W);
                den_next = dist_s_reg;
                rem_next = '0;
                quo_next = '0;
                ovf_next = 1'b0;
            end
            OP_MOVEX:
            begin
                pos_x_next = neg_x_reg ? pos_x_reg - quo_reg[POS_W-1:0]
                                       : pos_x_reg + quo_reg[POS_W-1:0];
            end
            OP_MOVEY:
            begin
                pos_y_next  = neg_y_reg ? pos_y_reg - quo_reg[POS_W-1:0]
                                        : pos_y_reg + quo_reg[POS_W-1:0];
                speed_next  = vel_reg;
                moving_next = 1'b1;
            end
            OP_EMIT:
            begin
                cam_x_next  = pos_x_reg;
                cam_y_next  = pos_y_reg;
                cam_mv_next = moving_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            approach_reg <= APPROACH_RESET;
            start_x_reg  <= '0;
            start_y_reg  <= '0;
            started_reg  <= 1'b0;
            pos_x_reg    <= '0;
            pos_y_reg    <= '0;
            last_x_reg   <= '0;
            last_y_reg   <= '0;
            speed_reg    <= '0;
            decel_reg    <= '0;
            new_tgt_reg  <= 1'b0;
            moving_reg   <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                case (wr_index)
                    CFG_APPROACH_TIME: approach_reg <= wr_data[TIME_W-1:0];
                    CFG_START_X:       start_x_reg  <= wr_data;
                    CFG_START_Y:       start_y_reg  <= wr_data;
                    default:           approach_reg <= approach_reg;
                endcase
            end
            started_reg <= started_next;
            pos_x_reg   <= pos_x_next;
            pos_y_reg   <= pos_y_next;
            last_x_reg  <= last_x_next;
            last_y_reg  <= last_y_next;
            speed_reg   <= speed_next;
            decel_reg   <= decel_next;
            new_tgt_reg <= new_tgt_next;
            moving_reg  <= moving_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dt_reg     <= dt_next;
        ax_reg     <= ax_next;
        ay_reg     <= ay_next;
        neg_x_reg  <= neg_x_next;
        neg_y_reg  <= neg_y_next;
        sh_reg     <= sh_next;
        sqx_reg    <= sqx_next;
        sqy_reg    <= sqy_next;
        rn_reg     <= rn_next;
        res_reg    <= res_next;
        bit_reg    <= bit_next;
        dist_s_reg <= dist_s_next;
        dist_reg   <= dist_next;
        num_reg    <= num_next;
        rem_reg    <= rem_next;
        den_reg    <= den_next;
        quo_reg    <= quo_next;
        ovf_reg    <= ovf_next;
        dec_reg    <= dec_next;
        vel_reg    <= vel_next;
        step_reg   <= step_next;
        cam_x_reg  <= cam_x_next;
        cam_y_reg  <= cam_y_next;
        cam_mv_reg <= cam_mv_next;
    end

    assign sts.new_tgt   = new_tgt_reg;
    assign sts.dist_zero = (dist_reg == '0);
    assign sts.dec_lt    = dec_reg < speed_reg;
    assign sts.step_lt   = step_reg < RATE_WIDTH'(dist_reg);

    assign cam_x  = cam_x_reg;
    assign cam_y  = cam_y_reg;
    assign moving = cam_mv_reg;

endmodule

`default_nettype wire

>>> src/dfol_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module dfol_ctrl
    import dfol_pkg::*;
#(
    parameter int RATE_WIDTH = DEF_RATE_WIDTH
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_stall,
    output logic         out_valid,
    input  wire logic    out_stall,
    output dp_cmd_t      cmd,
    input  wire dp_sts_t sts
);

    localparam int MAX_ITER = (RATE_WIDTH + TIME_W > MOVE_NUM_W) ? RATE_WIDTH + TIME_W
                                                                 : MOVE_NUM_W;
    localparam int CNT_W = $clog2(MAX_ITER + 1);

    ctl_state_t       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic             emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd.op     = OP_NONE;
        emit       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_DIFF;
                end
            end
            ST_DIFF:
            begin
                cmd.op     = OP_DIFF;
                state_next = ST_SQUARE;
            end
            ST_SQUARE:
            begin
                cmd.op     = OP_SQUARE;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.op     = OP_SUM;
                cnt_next   = CNT_W'(ROOT_STEPS);
                state_next = ST_ROOT;
            end
            ST_ROOT:
            begin
                cmd.op   = OP_ROOT;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                    state_next = ST_DIST;
            end
            ST_DIST:
            begin
                cmd.op     = OP_DIST;
                state_next = ST_ROUTE;
            end
            ST_ROUTE:
            begin
                if (sts.new_tgt)
                begin
                    cmd.op     = OP_DIV_LOAD_RAW;
                    cnt_next   = CNT_W'(RAW_NUM_W);
                    state_next = ST_DIV_RAW;
                end
                else if (sts.dist_zero)
                begin
                    cmd.op     = OP_STILL;
                    state_next = ST_EMIT;
                end
                else
                begin
                    cmd.op     = OP_DEC;
                    state_next = ST_VEL;
                end
            end
            ST_DIV_RAW:
            begin
                cmd.op   = OP_DIV_STEP;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                    state_next = ST_RAW;
            end
            ST_RAW:
            begin
                cmd.op     = OP_RAW;
                cnt_next   = CNT_W'(RATE_WIDTH + TIME_W);
                state_next = ST_DIV_DECEL;
            end
            ST_DIV_DECEL:
            begin
                cmd.op   = OP_DIV_STEP;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                    state_next = ST_DECEL;
            end
            ST_DECEL:
            begin
                cmd.op     = OP_DECEL;
                state_next = ST_ROUTE;
            end
            ST_VEL:
            begin
                if (sts.dec_lt)
                begin
                    cmd.op     = OP_VEL;
                    state_next = ST_STEP;
                end
                else
                begin
                    cmd.op     = OP_SNAP;
                    state_next = ST_EMIT;
                end
            end
            ST_STEP:
            begin
                cmd.op     = OP_STEP;
                state_next = ST_PRODX;
            end
            ST_PRODX:
            begin
                if (sts.step_lt)
                begin
                    cmd.op     = OP_PRODX;
                    cnt_next   = CNT_W'(MOVE_NUM_W);
                    state_next = ST_DIVX;
                end
                else
                begin
                    cmd.op     = OP_SNAP;
                    state_next = ST_EMIT;
                end
            end
            ST_DIVX:
            begin
                cmd.op   = OP_DIV_STEP;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                    state_next = ST_MOVEX;
            end
            ST_MOVEX:
            begin
                cmd.op     = OP_MOVEX;
                state_next = ST_PRODY;
            end
            ST_PRODY:
            begin
                cmd.op     = OP_PRODY;
                cnt_next   = CNT_W'(MOVE_NUM_W);
                state_next = ST_DIVY;
            end
            ST_DIVY:
            begin
                cmd.op   = OP_DIV_STEP;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                    state_next = ST_MOVEY;
            end
            ST_MOVEY:
            begin
                cmd.op     = OP_MOVEY;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                // hold until the output register is free or being drained
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.op     = OP_EMIT;
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        out_valid_next = (out_valid_reg & out_stall) | emit;
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

>>> src/decelerating_follow_2d_top.sv
// Work per word: the distance to the goal when the follower is at its target,
// plus the move when it moves, plus two bit-serial divides by the approach
// time when a new target starts an approach.
// The 32-step root and one-bit-per-cycle divider set the pace; a new word waits
// for the last to finish. The next word is taken while a result waits.
// Reset: asynchronous, active low; position, goal, speed and decel clear.
`timescale 1ns / 1ps
`default_nettype none

module decelerating_follow_2d_top
    import dfol_pkg::*;
#(
    parameter int RATE_WIDTH = DEF_RATE_WIDTH
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    wr_en,
    input  wire logic [1:0]              wr_index,
    input  wire logic [POS_W-1:0]        wr_data,
    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire logic [TIME_W-1:0]       tick_length,
    input  wire logic                    target_valid,
    input  wire logic signed [POS_W-1:0] goal_x,
    input  wire logic signed [POS_W-1:0] goal_y,
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output logic signed [POS_W-1:0]      cam_x,
    output logic signed [POS_W-1:0]      cam_y,
    output logic                         moving
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    dfol_ctrl #(
        .RATE_WIDTH (RATE_WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    dfol_datapath #(
        .RATE_WIDTH (RATE_WIDTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .wr_en        (wr_en),
        .wr_index     (wr_index),
        .wr_data      (wr_data),
        .tick_length  (tick_length),
        .target_valid (target_valid),
        .goal_x       (goal_x),
        .goal_y       (goal_y),
        .cmd          (cmd),
        .sts          (sts),
        .cam_x        (cam_x),
        .cam_y        (cam_y),
        .moving       (moving)
    );

endmodule

`default_nettype wire

>>> src/dfol_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module dfol_checker
    import dfol_pkg::*;
(
    input wire logic                    clk,
    input wire logic                    rst_n,
    input wire logic                    wr_en,
    input wire logic [1:0]              wr_index,
    input wire logic [POS_W-1:0]        wr_data,
    input wire logic                    in_valid,
    input wire logic                    in_stall,
    input wire logic [TIME_W-1:0]       tick_length,
    input wire logic                    target_valid,
    input wire logic signed [POS_W-1:0] goal_x,
    input wire logic signed [POS_W-1:0] goal_y,
    input wire logic                    out_valid,
    input wire logic                    out_stall,
    input wire logic signed [POS_W-1:0] cam_x,
    input wire logic signed [POS_W-1:0] cam_y,
    input wire logic                    moving
);

    // a stalled result stays up
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(cam_x) && $stable(cam_y) && $stable(moving))
        else $error("stalled result changed");

    // one word in flight: busy right after an accept
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second word taken while busy");

    // a new result only appears while a word is being worked on
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result without a word in flight");

endmodule

bind decelerating_follow_2d_top dfol_checker u_chk (.*);

`default_nettype wire
